// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever cond holds, prop must hold too.
`define SFPWD_ASSERT_IMPLIES(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("same-cycle implication violated");

// Next-cycle implication: whenever cond holds, prop must hold in the next cycle.
`define SFPWD_ASSERT_NEXT(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("next-cycle implication violated");

`endif

// ----- design/sfpwd_pkg.sv -----
// ----------------------------------------------------------------------------
// sfpwd_pkg
// Types and constants shared by the frame parser, decoder and top level.
// ----------------------------------------------------------------------------
package sfpwd_pkg;

   localparam logic [7:0] HDR_FIRST    = 8'hEF;
   localparam logic [7:0] HDR_SECOND   = 8'hDD;
   localparam logic [7:0] CMD_EVENT    = 8'd12;
   localparam logic [7:0] CMD_SETTINGS = 8'd8;
   localparam logic [7:0] EVT_WEIGHT   = 8'd5;
   localparam logic [7:0] EVT_WRAPPED  = 8'd11;
   localparam int         SIGN_BIT     = 1;
   localparam int         BODY_KEEP    = 9;

   localparam logic [6:0] BATTERY_MAX  = 7'd100;

   localparam logic       KIND_WEIGHT  = 1'b0;
   localparam logic       KIND_BATTERY = 1'b1;

   // A completed frame as handed from the parser to the decoder.
   typedef struct packed {
      logic [7:0]                 command;
      logic [7:0]                 length;
      logic [BODY_KEEP-1:0][7:0]  body;
      logic                       tenth_sign;
   } frame_type;

   typedef struct packed {
      logic        report_kind;
      logic [31:0] weight_raw;
      logic [2:0]  decimal_places;
      logic        weight_negative;
      logic [6:0]  battery_level;
   } result_type;

   // 4000 scaled by ten to the number of decimal places.
   function automatic logic [31:0] weight_limit(input logic [2:0] dec);
      logic [31:0] lim;
      unique case (dec)
         3'd2:    lim = 32'd400000;
         3'd3:    lim = 32'd4000000;
         3'd4:    lim = 32'd40000000;
         default: lim = 32'd40000;
      endcase
      return lim;
   endfunction

endpackage

// ----- design/sfpwd_parser.sv -----
// ----------------------------------------------------------------------------
// sfpwd_parser
// Byte-wise framing state machine with body capture and a frame register.
// ----------------------------------------------------------------------------
module sfpwd_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  byte_accept,
   input  logic [7:0]            data_byte,
   input  logic                  frame_take,
   output sfpwd_pkg::frame_type  frame,
   output logic                  frame_valid
);

   localparam logic [1:0] PH_HUNT    = 2'd0;
   localparam logic [1:0] PH_COMMAND = 2'd1;
   localparam logic [1:0] PH_LENGTH  = 2'd2;
   localparam logic [1:0] PH_BODY    = 2'd3;

   logic [1:0]  phase_ff, phase_in;
   logic        prev_start_ff, prev_start_in;
   logic [7:0]  command_ff, command_in;
   logic [7:0]  length_ff, length_in;
   logic [7:0]  count_ff, count_in;
   logic [sfpwd_pkg::BODY_KEEP-1:0][7:0] body_ff, body_in;
   logic        tenth_ff, tenth_in;
   logic        done;

   sfpwd_pkg::frame_type frame_ff, frame_in;
   logic                 frame_valid_ff, frame_valid_in;

   always_comb begin
      phase_in      = phase_ff;
      prev_start_in = prev_start_ff;
      command_in    = command_ff;
      length_in     = length_ff;
      count_in      = count_ff;
      body_in       = body_ff;
      tenth_in      = tenth_ff;
      done          = 1'b0;
      if (byte_accept) begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (prev_start_ff && data_byte == sfpwd_pkg::HDR_SECOND) begin
                  prev_start_in = 1'b0;
                  phase_in      = PH_COMMAND;
               end else begin
                  prev_start_in = (data_byte == sfpwd_pkg::HDR_FIRST);
               end
            end
            PH_COMMAND: begin
               command_in = data_byte;
               phase_in   = PH_LENGTH;
            end
            PH_LENGTH: begin
               length_in = data_byte;
               count_in  = '0;
               phase_in  = PH_BODY;
            end
            default: begin
               if (count_ff < 8'(sfpwd_pkg::BODY_KEEP)) begin
                  body_in[count_ff[3:0]] = data_byte;
               end
               if (count_ff == 8'(sfpwd_pkg::BODY_KEEP)) begin
                  tenth_in = data_byte[sfpwd_pkg::SIGN_BIT];
               end
               if (count_ff >= length_ff) begin
                  done          = 1'b1;
                  phase_in      = PH_HUNT;
                  prev_start_in = 1'b0;
                  count_in      = '0;
               end else begin
                  count_in = count_ff + 8'd1;
               end
            end
         endcase
      end
   end

   // The frame register holds a completed frame until the decoder side takes it.
   always_comb begin
      frame_in       = frame_ff;
      frame_valid_in = frame_valid_ff;
      if (done) begin
         frame_in.command    = command_ff;
         frame_in.length     = length_ff;
         frame_in.body       = body_in;
         frame_in.tenth_sign = tenth_in;
         frame_valid_in      = 1'b1;
      end else if (frame_take) begin
         frame_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HUNT;
         prev_start_ff  <= 1'b0;
         command_ff     <= '0;
         length_ff      <= '0;
         count_ff       <= '0;
         frame_valid_ff <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         prev_start_ff  <= prev_start_in;
         command_ff     <= command_in;
         length_ff      <= length_in;
         count_ff       <= count_in;
         frame_valid_ff <= frame_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      body_ff  <= body_in;
      tenth_ff <= tenth_in;
      frame_ff <= frame_in;
   end

   assign frame       = frame_ff;
   assign frame_valid = frame_valid_ff;

endmodule

// ----- design/sfpwd_decode.sv -----
// ----------------------------------------------------------------------------
// sfpwd_decode
// Turns a completed frame into a weight or battery report.
// ----------------------------------------------------------------------------
module sfpwd_decode (
   input  sfpwd_pkg::frame_type   frame,
   output logic                   hit,
   output sfpwd_pkg::result_type  result
);

   logic        is_event, is_settings, plain, wrapped, short_payload, neg;
   logic [7:0]  w0, w1, w2, w3, unit;
   logic [2:0]  dec;
   logic [31:0] be, le;
   logic [6:0]  batt7;

   always_comb begin
      is_event    = (frame.command == sfpwd_pkg::CMD_EVENT);
      is_settings = (frame.command == sfpwd_pkg::CMD_SETTINGS);
      plain       = (frame.body[0] == sfpwd_pkg::EVT_WEIGHT);
      wrapped     = (frame.body[0] == sfpwd_pkg::EVT_WRAPPED) && (frame.length >= 8'd3)
                    && (frame.body[3] == sfpwd_pkg::EVT_WEIGHT);

      // Six payload bytes are needed from the decode offset.
      if (wrapped) begin
         w0            = frame.body[4];
         w1            = frame.body[5];
         w2            = frame.body[6];
         w3            = frame.body[7];
         unit          = frame.body[8];
         neg           = frame.tenth_sign;
         short_payload = (frame.length < 8'd9);
      end else begin
         w0            = frame.body[1];
         w1            = frame.body[2];
         w2            = frame.body[3];
         w3            = frame.body[4];
         unit          = frame.body[5];
         neg           = frame.body[6][sfpwd_pkg::SIGN_BIT];
         short_payload = (frame.length < 8'd6);
      end

      dec = (unit >= 8'd1 && unit <= 8'd4) ? unit[2:0] : 3'd1;
      be  = {w0, w1, w2, w3};
      le  = {w3, w2, w1, w0};

      batt7 = frame.body[0][6:0];
      if (batt7 > sfpwd_pkg::BATTERY_MAX) begin
         batt7 = sfpwd_pkg::BATTERY_MAX;
      end

      hit    = (is_event && (plain || wrapped)) || is_settings;
      result = '{report_kind: sfpwd_pkg::KIND_WEIGHT, weight_raw: 32'd0,
                 decimal_places: 3'd1, weight_negative: 1'b0, battery_level: 7'd0};
      if (is_settings) begin
         result.report_kind   = sfpwd_pkg::KIND_BATTERY;
         result.battery_level = batt7;
      end else if (!short_payload) begin
         result.weight_raw      = (be <= sfpwd_pkg::weight_limit(dec)) ? be : le;
         result.decimal_places  = dec;
         result.weight_negative = neg;
      end
   end

endmodule

// ----- design/scale_frame_parser_weight_decode_top.sv -----
// ----------------------------------------------------------------------------
// scale_frame_parser_weight_decode_top
// Scale notification frame parser with weight and battery decoding.
// ----------------------------------------------------------------------------
// The block takes one stream byte per request and accepts a byte in every
// cycle unless it stalls as described below. It hunts for the header EF DD,
// then takes a command byte, a length byte L and L+1 body bytes; the first
// nine body bytes and the sign bit of the tenth are kept. When the last body
// byte of a frame arrives, the completed frame is held in a frame register.
// An event frame (command 12) whose body carries a weight event, or a
// settings frame (command 8), is then decoded by short combinational logic
// and placed in the result register; a report thus passes through the frame
// register and the result register to the result side. Every other byte and
// frame gives no report. The sustained rate of one byte a cycle is set by
// the framing state machine, which updates once per byte; the frame register
// holds one frame and the result register one report, so requests keep
// flowing while a report waits to be taken and stall only when both are full.
// report_kind travels on rsp_tuser; a battery report carries weight_raw 0,
// one decimal place and a clear sign, and a weight report battery level 0.
`include "assert_macros.svh"

module scale_frame_parser_weight_decode_top (
   input  logic        clock,
   input  logic        reset,
   // Request side: tdata = data_byte[7:0].
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   // Result side: tdata = weight_raw[31:0], decimal_places[34:32],
   // weight_negative[35], battery_level[42:36], zero fill[47:43].
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,
   // Result side: tuser = report_kind[0].
   output logic        rsp_tuser
);

   sfpwd_pkg::frame_type  frame;
   sfpwd_pkg::result_type decoded;
   logic                  frame_valid;
   logic                  hit;
   logic                  byte_accept;
   logic                  out_ready;

   sfpwd_pkg::result_type rsp_data_ff, rsp_data_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // The result register can load whenever it is empty or being emptied.
   assign out_ready   = !rsp_valid_ff || rsp_tready;
   // A new byte can always be taken unless a finished frame is stuck behind
   // a full result register.
   assign req_tready  = !frame_valid || out_ready;
   assign byte_accept = req_tvalid && req_tready;

   sfpwd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (byte_accept),
      .data_byte   (req_tdata),
      .frame_take  (out_ready),
      .frame       (frame),
      .frame_valid (frame_valid)
   );

   sfpwd_decode u_decode (
      .frame  (frame),
      .hit    (hit),
      .result (decoded)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_ready) begin
         rsp_valid_in = frame_valid && hit;
         rsp_data_in  = decoded;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_data_ff.report_kind;
   assign rsp_tdata  = {5'd0, rsp_data_ff.battery_level, rsp_data_ff.weight_negative,
                        rsp_data_ff.decimal_places, rsp_data_ff.weight_raw};

   // A reported decimal count always lies in the range one to four.
   `SFPWD_ASSERT_IMPLIES(a_dec_range, rsp_valid_ff,
      rsp_data_ff.decimal_places >= 3'd1 && rsp_data_ff.decimal_places <= 3'd4)
   // Battery reports are clamped and carry no weight.
   `SFPWD_ASSERT_IMPLIES(a_batt_clean, rsp_valid_ff && rsp_data_ff.report_kind,
      rsp_data_ff.battery_level <= 7'd100 && rsp_data_ff.weight_raw == 32'd0)
   // Weight reports carry no battery level.
   `SFPWD_ASSERT_IMPLIES(a_weight_clean, rsp_valid_ff && !rsp_data_ff.report_kind,
      rsp_data_ff.battery_level == 7'd0)
   // With both registers full, no byte may be taken.
   `SFPWD_ASSERT_IMPLIES(a_full_stall, frame_valid && rsp_valid_ff && !rsp_tready,
      !req_tready)
   // A completed frame that cannot move on is kept for the next cycle.
   `SFPWD_ASSERT_NEXT(a_frame_held, frame_valid && !out_ready, frame_valid)

endmodule
